>>> src/bbc_pkg.sv
// ----------------------------------------------------------------------------
// Block buffer cache controller package
// Shared types, field widths, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package bbc_pkg;

	localparam int NUM_BUFFERS_DEF = 4;
	localparam int BLOCK_BYTES_DEF = 1024;
	localparam int OFFSET_BITS_DEF = 31;

	localparam int FILE_OFF_W = 31;
	localparam int BLOCK_NUM_W = 21;
	localparam int BUF_IDX_W = 2;
	localparam int BYTE_POS_W = 10;
	localparam int XFER_LEN_W = 11;

	localparam logic OP_STORE = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef logic [FILE_OFF_W-1:0] file_off_t;
	typedef logic [BLOCK_NUM_W-1:0] block_num_t;
	typedef logic [BUF_IDX_W-1:0] buf_idx_t;
	typedef logic [BYTE_POS_W-1:0] byte_pos_t;
	typedef logic [XFER_LEN_W-1:0] xfer_len_t;
	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		CMD_STORE = 2'd0,
		CMD_WRITE_BACK = 2'd1,
		CMD_FILL = 2'd2,
		CMD_FLUSH_DONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic opcode;
		file_off_t byte_offset;
		byte_t byte_value;
	} in_item_t;

	typedef struct packed {
		cmd_t command;
		buf_idx_t buffer_index;
		block_num_t block_number;
		byte_pos_t byte_in_block;
		byte_t store_value;
		xfer_len_t transfer_length;
		file_off_t pad_from;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic valid_clr;
		logic valid_set;
		logic size_we;
		logic top_we;
		logic victim_step;
	} tag_upd_t;

endpackage

>>> src/bbc_tag_store.sv
// ----------------------------------------------------------------------------
// Buffer tag store
// Valid bits, block numbers and fill sizes of the buffers, the victim
// pointer and the file top, updated by one command per cycle under en.
// ----------------------------------------------------------------------------
module bbc_tag_store import bbc_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input tag_upd_t upd,
	input logic [$clog2(NUM_BUFFERS)-1:0] upd_idx,
	input logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W)
		- $clog2(BLOCK_BYTES)-1:0] upd_block,
	input logic [$clog2(BLOCK_BYTES):0] upd_size,
	input logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W):0] upd_top,
	output logic entry_valid [NUM_BUFFERS],
	output logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W)
		- $clog2(BLOCK_BYTES)-1:0] entry_block [NUM_BUFFERS],
	output logic [$clog2(BLOCK_BYTES):0] entry_size [NUM_BUFFERS],
	output logic [$clog2(NUM_BUFFERS)-1:0] victim,
	output logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W):0] file_top
);

	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int BB_W = $clog2(BLOCK_BYTES);
	localparam int OFF_W = (OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W;
	localparam int BLK_W = OFF_W - BB_W;
	localparam int SIZE_W = BB_W + 1;
	localparam int TOP_W = OFF_W + 1;

	logic valid_q [NUM_BUFFERS];
	logic [BLK_W-1:0] block_q [NUM_BUFFERS];
	logic [SIZE_W-1:0] size_q [NUM_BUFFERS];
	logic [IDX_W-1:0] victim_q;
	logic [TOP_W-1:0] top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BUFFERS; i++) begin
				valid_q[i] <= 1'b0;
				block_q[i] <= '0;
				size_q[i] <= '0;
			end
			victim_q <= IDX_W'(NUM_BUFFERS - 1);
			top_q <= '0;
		end else if (en) begin
			if (upd.valid_clr) begin
				valid_q[upd_idx] <= 1'b0;
			end
			if (upd.valid_set) begin
				valid_q[upd_idx] <= 1'b1;
				block_q[upd_idx] <= upd_block;
			end
			if (upd.size_we) begin
				size_q[upd_idx] <= upd_size;
			end
			if (upd.top_we) begin
				top_q <= upd_top;
			end
			if (upd.victim_step) begin
				victim_q <= (victim_q == '0) ? IDX_W'(NUM_BUFFERS - 1) : victim_q - IDX_W'(1);
			end
		end
	end

	assign entry_valid = valid_q;
	assign entry_block = block_q;
	assign entry_size = size_q;
	assign victim = victim_q;
	assign file_top = top_q;

endmodule

>>> src/bbc_cmd_gen.sv
// ----------------------------------------------------------------------------
// Command generator
// Picks the next command for the pending transaction from the tag state:
// a store on a hit, otherwise write-back of a valid victim and then a fill,
// and for a flush the lowest valid block until none is left.
// ----------------------------------------------------------------------------
module bbc_cmd_gen import bbc_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input in_item_t item,
	input logic entry_valid [NUM_BUFFERS],
	input logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W)
		- $clog2(BLOCK_BYTES)-1:0] entry_block [NUM_BUFFERS],
	input logic [$clog2(BLOCK_BYTES):0] entry_size [NUM_BUFFERS],
	input logic [$clog2(NUM_BUFFERS)-1:0] victim,
	input logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W):0] file_top,
	output out_item_t res,
	output tag_upd_t upd,
	output logic [$clog2(NUM_BUFFERS)-1:0] upd_idx,
	output logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W)
		- $clog2(BLOCK_BYTES)-1:0] upd_block,
	output logic [$clog2(BLOCK_BYTES):0] upd_size,
	output logic [((OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W):0] upd_top
);

	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int BB_W = $clog2(BLOCK_BYTES);
	localparam int OFF_W = (OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W;
	localparam int BLK_W = OFF_W - BB_W;
	localparam int SIZE_W = BB_W + 1;
	localparam int TOP_W = OFF_W + 1;

	logic [OFF_W-1:0] off;
	logic [BLK_W-1:0] blk;
	logic [BB_W-1:0] pos;
	logic hit;
	logic [IDX_W-1:0] hit_idx;
	logic found;
	logic [IDX_W-1:0] low_idx;
	logic [IDX_W-1:0] wb_idx;
	logic [TOP_W-1:0] wb_base;
	logic [TOP_W-1:0] wb_end;
	logic [TOP_W-1:0] wb_pad;
	logic [TOP_W-1:0] fill_base;
	logic [TOP_W-1:0] fill_diff;
	logic [SIZE_W-1:0] fill_len;
	logic [SIZE_W-1:0] pos_ext;
	logic [SIZE_W-1:0] cur_size;
	logic [SIZE_W-1:0] st_size;

	assign off = item.byte_offset[OFF_W-1:0];
	assign blk = off[OFF_W-1:BB_W];
	assign pos = off[BB_W-1:0];

	always_comb begin
		hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (!hit && entry_valid[i] && entry_block[i] == blk) begin
				hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		found = 1'b0;
		low_idx = '0;
		for (int i = 0; i < NUM_BUFFERS; i++) begin
			if (entry_valid[i] && (!found || entry_block[i] < entry_block[low_idx])) begin
				found = 1'b1;
				low_idx = IDX_W'(i);
			end
		end
	end

	always_comb begin
		wb_idx = (item.opcode == OP_FLUSH) ? low_idx : victim;
		wb_base = TOP_W'({entry_block[wb_idx], {BB_W{1'b0}}});
		wb_end = wb_base + TOP_W'(entry_size[wb_idx]);
		wb_pad = (file_top < wb_base) ? file_top : wb_base;

		fill_base = TOP_W'({blk, {BB_W{1'b0}}});
		fill_diff = file_top - fill_base;
		if (fill_base < file_top) begin
			fill_len = (fill_diff > TOP_W'(BLOCK_BYTES)) ? SIZE_W'(BLOCK_BYTES)
				: fill_diff[SIZE_W-1:0];
		end else begin
			fill_len = '0;
		end

		pos_ext = SIZE_W'(pos);
		cur_size = entry_size[hit_idx];
		st_size = (cur_size <= pos_ext) ? pos_ext + SIZE_W'(1) : cur_size;
	end

	always_comb begin
		res = '0;
		upd = '0;
		upd_idx = '0;
		upd_block = blk;
		upd_size = '0;
		upd_top = (wb_end > file_top) ? wb_end : file_top;

		if ((item.opcode == OP_FLUSH && found) ||
			(item.opcode == OP_STORE && !hit && entry_valid[victim])) begin
			res.command = CMD_WRITE_BACK;
			res.buffer_index = buf_idx_t'(wb_idx);
			res.block_number = block_num_t'(entry_block[wb_idx]);
			res.transfer_length = xfer_len_t'(entry_size[wb_idx]);
			res.pad_from = file_off_t'(wb_pad);
			upd.valid_clr = 1'b1;
			upd.top_we = 1'b1;
			upd_idx = wb_idx;
		end else if (item.opcode == OP_FLUSH) begin
			res.command = CMD_FLUSH_DONE;
			res.last = 1'b1;
		end else if (hit) begin
			res.command = CMD_STORE;
			res.buffer_index = buf_idx_t'(hit_idx);
			res.block_number = block_num_t'(blk);
			res.byte_in_block = byte_pos_t'(pos);
			res.store_value = item.byte_value;
			res.last = 1'b1;
			upd.size_we = 1'b1;
			upd_idx = hit_idx;
			upd_size = st_size;
		end else begin
			res.command = CMD_FILL;
			res.buffer_index = buf_idx_t'(victim);
			res.block_number = block_num_t'(blk);
			res.transfer_length = xfer_len_t'(fill_len);
			upd.valid_set = 1'b1;
			upd.size_we = 1'b1;
			upd.victim_step = 1'b1;
			upd_idx = victim;
			upd_size = fill_len;
		end
	end

endmodule

>>> src/block_buffer_cache_controller.sv
// ----------------------------------------------------------------------------
// Block buffer cache controller
// Tag and control logic for write-back block buffers in front of a file.
// ----------------------------------------------------------------------------
// Each input transaction on item (item_valid/item_stall) is a byte store or
// a flush. It is held in an input register and turned into one to
// NUM_BUFFERS+1 commands on result (result_valid/result_stall), one per
// cycle unless stalled, the final one marked by last. A store hit gives
// one command, a miss gives an optional write-back, a fill and the store.
// A flush gives a write-back for each valid buffer in ascending block order
// and then flush done.
// The first command is formed from the input register and leaves through
// the output register. One command is produced per cycle unless a command
// waits under result_stall; the next input is taken in the cycle that
// produces the last command of the current one, so unstalled hits run at
// one transaction per cycle. The output register is the pacing element.
// While a command waits in the output register under result_stall, the
// register holds and item_stall stays high for a pending transaction.
// cfg_data (cfg_valid/cfg_ready) sets output enable; with it low, inputs
// are taken and dropped.
// Reset empties all buffers, clears the file top, sets the victim pointer
// to the highest buffer and sets output enable.
// ----------------------------------------------------------------------------
module block_buffer_cache_controller import bbc_pkg::*; #(
	parameter int NUM_BUFFERS = NUM_BUFFERS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input in_item_t item,
	output logic result_valid,
	input logic result_stall,
	output out_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic cfg_data
);

	localparam int IDX_W = $clog2(NUM_BUFFERS);
	localparam int BB_W = $clog2(BLOCK_BYTES);
	localparam int OFF_W = (OFFSET_BITS < FILE_OFF_W) ? OFFSET_BITS : FILE_OFF_W;
	localparam int BLK_W = OFF_W - BB_W;
	localparam int SIZE_W = BB_W + 1;
	localparam int TOP_W = OFF_W + 1;

	logic enable_q;
	logic busy_s1;
	in_item_t item_s1;
	logic res_valid_q;
	out_item_t res_q;

	logic step;
	logic done;
	logic take;
	out_item_t res_next;
	tag_upd_t upd;
	logic [IDX_W-1:0] upd_idx;
	logic [BLK_W-1:0] upd_block;
	logic [SIZE_W-1:0] upd_size;
	logic [TOP_W-1:0] upd_top;
	logic entry_valid [NUM_BUFFERS];
	logic [BLK_W-1:0] entry_block [NUM_BUFFERS];
	logic [SIZE_W-1:0] entry_size [NUM_BUFFERS];
	logic [IDX_W-1:0] victim;
	logic [TOP_W-1:0] file_top;

	assign step = busy_s1 && (!res_valid_q || !result_stall);
	assign done = step && res_next.last;
	assign item_stall = busy_s1 && !done;
	assign take = item_valid && !item_stall;
	assign cfg_ready = 1'b1;
	assign result_valid = res_valid_q;
	assign result = res_q;

	bbc_cmd_gen #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.BLOCK_BYTES(BLOCK_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_cmd_gen (
		.item(item_s1),
		.entry_valid(entry_valid),
		.entry_block(entry_block),
		.entry_size(entry_size),
		.victim(victim),
		.file_top(file_top),
		.res(res_next),
		.upd(upd),
		.upd_idx(upd_idx),
		.upd_block(upd_block),
		.upd_size(upd_size),
		.upd_top(upd_top)
	);

	bbc_tag_store #(
		.NUM_BUFFERS(NUM_BUFFERS),
		.BLOCK_BYTES(BLOCK_BYTES),
		.OFFSET_BITS(OFFSET_BITS)
	) u_tag_store (
		.clk(clk),
		.arst_n(arst_n),
		.en(step),
		.upd(upd),
		.upd_idx(upd_idx),
		.upd_block(upd_block),
		.upd_size(upd_size),
		.upd_top(upd_top),
		.entry_valid(entry_valid),
		.entry_block(entry_block),
		.entry_size(entry_size),
		.victim(victim),
		.file_top(file_top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
		end else if (take) begin
			busy_s1 <= enable_q;
		end else if (done) begin
			busy_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_next;
		end
	end

	a_last_marks_final: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.last == (res_q.command == CMD_STORE ||
			res_q.command == CMD_FLUSH_DONE)))
		else $error("last does not match the command kind");

	a_fill_then_store: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_next.command == CMD_FILL |=> busy_s1 && res_next.command == CMD_STORE)
		else $error("a fill was not followed by its store");

	a_disabled_drops: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q && !busy_s1 |=> !busy_s1)
		else $error("transaction taken while output is disabled");

	a_stall_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> busy_s1 && !(step && res_next.last))
		else $error("input stalled without a pending transaction");

	a_victim_invalid_on_fill: assert property (@(posedge clk) disable iff (!arst_n)
		step && upd.valid_set |-> !entry_valid[upd_idx])
		else $error("fill into a buffer that is still valid");

endmodule
